/* hw/rtl/greedy_peak_suppression_assert.svh */
// Assertion macros used by the checker file of the peak suppression block.
`ifndef GREEDY_PEAK_SUPPRESSION_ASSERT_SVH
`define GREEDY_PEAK_SUPPRESSION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gps_pkg.sv */
// ----------------------------------------------------------------------------
// gps_pkg
// Types and constants of the greedy peak suppression block.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int unsigned ScoreW  = 16;
  localparam int unsigned CfgDimW = 7;
  localparam int unsigned RadiusW = 5;
  localparam int unsigned HitW    = 10;
  localparam int unsigned CoordW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Operation codes of an input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MAP_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAP_HEIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BLOT_RADIUS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HIT_LIMIT   = 3'd4;

  // Configuration reset values
  localparam logic [CfgDimW-1:0] RST_MAP_WIDTH   = 7'd64;
  localparam logic [CfgDimW-1:0] RST_MAP_HEIGHT  = 7'd64;
  localparam logic [ScoreW-1:0]  RST_THRESHOLD   = 16'd45875;
  localparam logic [RadiusW-1:0] RST_BLOT_RADIUS = 5'd5;
  localparam logic [HitW-1:0]    RST_HIT_LIMIT   = 10'd301;

  typedef struct packed {
    logic              op;
    logic [ScoreW-1:0] score;
    logic              first_element;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] peak_x;
    logic [CoordW-1:0] peak_y;
    logic [ScoreW-1:0] peak_score;
    logic              last;
  } out_item_t;

  // Control from the sequencer to the max tracking unit
  typedef struct packed {
    logic clear;
    logic sample;
  } mx_ctl_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_BOUNDS = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_BLOT   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_e;

endpackage

/* hw/rtl/gps_ram.sv */
// ----------------------------------------------------------------------------
// gps_ram
// Single-port RAM, write and registered read through one address.
// ----------------------------------------------------------------------------
module gps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gps_max_unit.sv */
// ----------------------------------------------------------------------------
// gps_max_unit
// Running maximum over a stream of scores, first in scan order on ties.
// ----------------------------------------------------------------------------
module gps_max_unit import gps_pkg::*; #(
  parameter int unsigned XW = 6,
  parameter int unsigned YW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mx_ctl_t           ctl_i,
  input  logic [ScoreW-1:0] score_i,
  input  logic [XW-1:0]     x_i,
  input  logic [YW-1:0]     y_i,
  output logic [ScoreW-1:0] best_score_o,
  output logic [XW-1:0]     best_x_o,
  output logic [YW-1:0]     best_y_o
);

  logic              any_q;
  logic [ScoreW-1:0] best_q;
  logic [XW-1:0]     bx_q;
  logic [YW-1:0]     by_q;
  logic              take;

  // Strictly greater keeps the earliest of equal scores
  assign take = ctl_i.sample && (!any_q || (score_i > best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (ctl_i.clear) begin
      any_q <= 1'b0;
    end else if (ctl_i.sample) begin
      any_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= score_i;
      bx_q   <= x_i;
      by_q   <= y_i;
    end
  end

  assign best_score_o = best_q;
  assign best_x_o     = bx_q;
  assign best_y_o     = by_q;

endmodule

/* hw/rtl/greedy_peak_suppression.sv */
// ----------------------------------------------------------------------------
// greedy_peak_suppression
// Score map store with greedy peak search and square suppression.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries load and find
//   items. A load writes one score in row-major order and gives no result;
//   loads stream at one per cycle while no find holds the input. A find
//   scans the map for its largest score, zeroes the square around it,
//   rescans for the remaining maximum and then gives one result on the
//   output channel. Its states run scan, drain, bounds, multiply, blot (the
//   B cells of the clipped square, at most 4*R*R for radius R), then scan,
//   drain and result; with R zero multiply and blot drop out. The two scans
//   dominate, set by the single port of the score store, which sees one
//   read or one write per cycle. A find after the search has ended goes
//   straight to the result state, which fills the output register once it
//   is free. in_stall_o stays high while a find is in progress, so the next
//   item can follow in the cycle after the result is written.
//   The result sits in an output register until transferred; a stalled
//   receiver holds it, and a new item may be taken meanwhile. A further
//   result waits in the final state until the register frees up.
//   Reset clears the control state and the configuration to defaults and
//   marks the search as ended; the score store keeps no reset value.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once and are meant for idle periods.
// ----------------------------------------------------------------------------
module greedy_peak_suppression import gps_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW = $clog2(Depth + 1);
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned BW = ((XW > YW) ? XW : YW) + 7;

  // Configuration registers
  logic [CfgDimW-1:0] cfg_w_q, cfg_h_q;
  logic [ScoreW-1:0]  thr_q;
  logic [RadiusW-1:0] rad_q;
  logic [HitW-1:0]    lim_q;

  // Control state
  state_e         state_q, state_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [HitW-1:0] hits_q, hits_d;
  logic           fin_q, fin_d;
  logic           fin_req_q, fin_req_d;
  logic           pass_q, pass_d;
  logic           rd_vld_q, rd_vld_d;
  logic           out_vld_q, out_vld_d;

  // Datapath registers
  logic [XW-1:0]     x_q, x_d, rd_x_q, rd_x_d;
  logic [YW-1:0]     y_q, y_d, rd_y_q, rd_y_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [XW-1:0]     pk_x_q, pk_x_d;
  logic [YW-1:0]     pk_y_q, pk_y_d;
  logic [ScoreW-1:0] pk_s_q, pk_s_d;
  logic [XW-1:0]     xs_q, xs_d, xe_q, xe_d, cx_q, cx_d;
  logic [YW-1:0]     ys_q, ys_d, ye_q, ye_d, cy_q, cy_d;
  logic [AW-1:0]     row_q, row_d;
  out_item_t         out_q, out_d;

  // Store port and max unit
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [ScoreW-1:0] ram_wdata, ram_rdata;
  mx_ctl_t           mx_ctl;
  logic [ScoreW-1:0] mx_score;
  logic [XW-1:0]     mx_x;
  logic [YW-1:0]     mx_y;

  // Effective dimensions and bounds
  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic [XW-1:0]        wm1;
  logic [YW-1:0]        hm1;
  logic signed [BW-1:0] px_s, py_s, r_s, wm1_s, hm1_s;
  logic signed [BW-1:0] xlo, xhi, ylo, yhi;
  logic [PW-1:0]        load_pos;
  logic [PW-1:0]        base_full;
  logic                 in_xfer, out_free, done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  // Clamp the configured map size into the store
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_h_q);
    end
  end

  assign wm1 = XW'(w_eff - 1'b1);
  assign hm1 = YW'(h_eff - 1'b1);

  // Clipped square around the peak just found
  always_comb begin
    px_s  = BW'(mx_x);
    py_s  = BW'(mx_y);
    r_s   = BW'(rad_q);
    wm1_s = BW'(wm1);
    hm1_s = BW'(hm1);
    xlo   = px_s - r_s;
    xhi   = px_s + r_s - BW'(1);
    ylo   = py_s - r_s;
    yhi   = py_s + r_s - BW'(1);
    if (xlo < 0) xlo = '0;
    if (ylo < 0) ylo = '0;
    if (xhi > wm1_s) xhi = wm1_s;
    if (yhi > hm1_s) yhi = hm1_s;
  end

  assign load_pos  = in_data_i.first_element ? '0 : pos_q;
  assign base_full = PW'(ys_q) * PW'(w_eff);
  assign done      = (hits_q >= lim_q) || (mx_score <= thr_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RST_MAP_WIDTH;
      cfg_h_q <= RST_MAP_HEIGHT;
      thr_q   <= RST_THRESHOLD;
      rad_q   <= RST_BLOT_RADIUS;
      lim_q   <= RST_HIT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_WIDTH:   cfg_w_q <= cfg_wdata_i[CfgDimW-1:0];
        REG_MAP_HEIGHT:  cfg_h_q <= cfg_wdata_i[CfgDimW-1:0];
        REG_THRESHOLD:   thr_q   <= cfg_wdata_i[ScoreW-1:0];
        REG_BLOT_RADIUS: rad_q   <= cfg_wdata_i[RadiusW-1:0];
        REG_HIT_LIMIT:   lim_q   <= cfg_wdata_i[HitW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    hits_d    = hits_q;
    fin_d     = fin_q;
    fin_req_d = fin_req_q;
    pass_d    = pass_q;
    rd_vld_d  = 1'b0;
    out_vld_d = out_vld_q;
    x_d       = x_q;
    y_d       = y_q;
    rd_x_d    = rd_x_q;
    rd_y_d    = rd_y_q;
    addr_d    = addr_q;
    pk_x_d    = pk_x_q;
    pk_y_d    = pk_y_q;
    pk_s_d    = pk_s_q;
    xs_d      = xs_q;
    xe_d      = xe_q;
    ys_d      = ys_q;
    ye_d      = ye_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    row_d     = row_q;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    mx_ctl    = '0;
    mx_ctl.sample = rd_vld_q;

    // Drop the held result once transferred
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.op == OP_LOAD) begin
            if (in_data_i.first_element) begin
              hits_d = '0;
              fin_d  = 1'b0;
            end
            // Ignore loads past the end of the store
            if (load_pos < PW'(Depth)) begin
              ram_we    = 1'b1;
              ram_addr  = load_pos[AW-1:0];
              ram_wdata = in_data_i.score;
              pos_d     = load_pos + 1'b1;
            end else begin
              pos_d = load_pos;
            end
          end else if (fin_q) begin
            fin_req_d = 1'b1;
            state_d   = ST_RESULT;
          end else begin
            fin_req_d    = 1'b0;
            pass_d       = 1'b0;
            x_d          = '0;
            y_d          = '0;
            addr_d       = '0;
            mx_ctl.clear = 1'b1;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        rd_vld_d = 1'b1;
        rd_x_d   = x_q;
        rd_y_d   = y_q;
        addr_d   = addr_q + 1'b1;
        if (x_q == wm1) begin
          x_d = '0;
          if (y_q == hm1) begin
            state_d = ST_DRAIN;
          end else begin
            y_d = y_q + 1'b1;
          end
        end else begin
          x_d = x_q + 1'b1;
        end
      end

      ST_DRAIN: begin
        state_d = pass_q ? ST_RESULT : ST_BOUNDS;
      end

      ST_BOUNDS: begin
        pk_x_d = mx_x;
        pk_y_d = mx_y;
        pk_s_d = mx_score;
        hits_d = hits_q + 1'b1;
        xs_d   = XW'(xlo);
        xe_d   = XW'(xhi);
        ys_d   = YW'(ylo);
        ye_d   = YW'(yhi);
        if (rad_q == '0) begin
          pass_d       = 1'b1;
          x_d          = '0;
          y_d          = '0;
          addr_d       = '0;
          mx_ctl.clear = 1'b1;
          state_d      = ST_SCAN;
        end else begin
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        row_d   = base_full[AW-1:0];
        cx_d    = xs_q;
        cy_d    = ys_q;
        state_d = ST_BLOT;
      end

      ST_BLOT: begin
        ram_we    = 1'b1;
        ram_addr  = row_q + AW'(cx_q);
        ram_wdata = '0;
        if (cx_q == xe_q) begin
          cx_d  = xs_q;
          cy_d  = cy_q + 1'b1;
          row_d = row_q + AW'(w_eff);
          if (cy_q == ye_q) begin
            pass_d       = 1'b1;
            x_d          = '0;
            y_d          = '0;
            addr_d       = '0;
            mx_ctl.clear = 1'b1;
            state_d      = ST_SCAN;
          end
        end else begin
          cx_d = cx_q + 1'b1;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (fin_req_q) begin
            out_d      = '0;
            out_d.last = 1'b1;
          end else begin
            out_d.found      = 1'b1;
            out_d.peak_x     = CoordW'(pk_x_q);
            out_d.peak_y     = CoordW'(pk_y_q);
            out_d.peak_score = pk_s_q;
            out_d.last       = done;
            if (done) begin
              fin_d = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      hits_q    <= '0;
      fin_q     <= 1'b1;
      fin_req_q <= 1'b0;
      pass_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      hits_q    <= hits_d;
      fin_q     <= fin_d;
      fin_req_q <= fin_req_d;
      pass_q    <= pass_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    rd_x_q <= rd_x_d;
    rd_y_q <= rd_y_d;
    addr_q <= addr_d;
    pk_x_q <= pk_x_d;
    pk_y_q <= pk_y_d;
    pk_s_q <= pk_s_d;
    xs_q   <= xs_d;
    xe_q   <= xe_d;
    ys_q   <= ys_d;
    ye_q   <= ye_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    row_q  <= row_d;
    out_q  <= out_d;
  end

  gps_ram #(
    .Width (ScoreW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  gps_max_unit #(
    .XW (XW),
    .YW (YW)
  ) u_max (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mx_ctl),
    .score_i      (ram_rdata),
    .x_i          (rd_x_q),
    .y_i          (rd_y_q),
    .best_score_o (mx_score),
    .best_x_o     (mx_x),
    .best_y_o     (mx_y)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/gps_checker.sv */
// ----------------------------------------------------------------------------
// gps_checker
// Port-level checks of the greedy peak suppression block.
// ----------------------------------------------------------------------------
`include "greedy_peak_suppression_assert.svh"

module gps_checker import gps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // A stalled result holds
  `GPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  // A find keeps the input side busy in the next cycle
  `GPS_ASSERT_NEXT(a_find_busy, clk_i, rst_ni, in_xfer && (in_data_i.op == OP_FIND),
    in_stall_o, "find transfer did not occupy the block")

  // A load leaves the input free in the next cycle
  `GPS_ASSERT_NEXT(a_load_free, clk_i, rst_ni, in_xfer && (in_data_i.op == OP_LOAD),
    !in_stall_o, "load transfer stalled the input")

  // An empty result is a final one with cleared fields
  `GPS_ASSERT_NOW(a_empty_res, clk_i, rst_ni, out_valid_o && !out_data_o.found,
    out_data_o.last && (out_data_o.peak_x == '0) && (out_data_o.peak_y == '0) &&
    (out_data_o.peak_score == '0), "empty result with stray fields")

endmodule

bind greedy_peak_suppression gps_checker u_gps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/tb_greedy_peak_suppression.sv */
// ----------------------------------------------------------------------------
// tb_greedy_peak_suppression
// Self-checking bench for the greedy peak search with square suppression.
// Loads score maps and sends find requests over the valid/stall input
// channel. A shadow copy of the map and the search state predicts each
// peak report not typed by hand. Reports are compared field by field as
// they transfer out. Both channels idle and stall at random. The register
// settings change between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb_greedy_peak_suppression;
  import gps_pkg::*;

  localparam int unsigned MapW        = 64;
  localparam int unsigned MapH        = 64;
  localparam int unsigned Depth       = MapW * MapH;
  localparam int unsigned RandomItems = 1600;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned StallLimit  = 100000;

  localparam out_item_t NOT_FOUND = '{found: 1'b0, peak_x: '0, peak_y: '0,
                                      peak_score: '0, last: 1'b1};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  greedy_peak_suppression #(
    .MAX_WIDTH (MapW),
    .MAX_HEIGHT(MapH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow state of the block
  // --------------------------------------------------------------------------
  logic [ScoreW-1:0]  score_mem [Depth];
  int unsigned        load_pos    = 0;
  int unsigned        high_water  = 0;  // entries below this have been written
  int unsigned        hits        = 0;
  bit                 search_done = 1'b1;
  logic [CfgDimW-1:0] reg_width   = RST_MAP_WIDTH;
  logic [CfgDimW-1:0] reg_height  = RST_MAP_HEIGHT;
  logic [ScoreW-1:0]  reg_thr     = RST_THRESHOLD;
  logic [RadiusW-1:0] reg_radius  = RST_BLOT_RADIUS;
  logic [HitW-1:0]    reg_limit   = RST_HIT_LIMIT;

  out_item_t          peaks_due [$];  // reports still to come, oldest first
  int unsigned        mismatches  = 0;
  int unsigned        sent        = 0;
  int unsigned        idle_cycles = 0;
  bit                 in_calm     = 1'b0;
  bit                 out_calm    = 1'b0;
  logic [ScoreW-1:0]  tie_score   = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;  // report below is written out by hand
    out_item_t peak;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Map size registers: zero acts as one, oversize acts as the maximum.
  function automatic int unsigned used_dim(logic [CfgDimW-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // First largest score in scan order over the active window.
  function automatic logic [ScoreW-1:0] scan_best(int unsigned w, int unsigned h,
                                                 output int unsigned bx,
                                                 output int unsigned by);
    logic [ScoreW-1:0] best;
    best = score_mem[0];
    bx   = 0;
    by   = 0;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if (score_mem[y * w + x] > best) begin
          best = score_mem[y * w + x];
          bx   = x;
          by   = y;
        end
      end
    end
    return best;
  endfunction

  // Apply one accepted item to the shadow state. Returns 1 when the item
  // produces a report, which is then left in res.
  function automatic bit take_item(in_item_t it, output out_item_t res);
    int unsigned       w, h, px, py, rx, ry;
    int                r;
    logic [ScoreW-1:0] peak, rest;
    res = NOT_FOUND;
    if (it.op == OP_LOAD) begin
      if (it.first_element) begin
        load_pos    = 0;
        hits        = 0;
        search_done = 1'b0;
      end
      // Drop loads once the store is full; the position stays put.
      if (load_pos < Depth) begin
        score_mem[load_pos] = it.score;
        load_pos++;
        if (load_pos > high_water) high_water = load_pos;
      end
      return 1'b0;
    end
    if (search_done) return 1'b1;
    w    = used_dim(reg_width, MapW);
    h    = used_dim(reg_height, MapH);
    peak = scan_best(w, h, px, py);
    // Zero the square [p - r, p + r - 1] in both axes, clipped to the window.
    r = int'(reg_radius);
    for (int yy = int'(py) - r; yy < int'(py) + r; yy++) begin
      for (int xx = int'(px) - r; xx < int'(px) + r; xx++) begin
        if (yy >= 0 && yy < int'(h) && xx >= 0 && xx < int'(w))
          score_mem[yy * int'(w) + xx] = '0;
      end
    end
    hits++;
    rest           = scan_best(w, h, rx, ry);
    res.found      = 1'b1;
    res.peak_x     = CoordW'(px);
    res.peak_y     = CoordW'(py);
    res.peak_score = peak;
    res.last       = (hits >= reg_limit) || (rest <= reg_thr);
    if (res.last) search_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Scores around the threshold and repeated values make ties and borderline
  // stops likely.
  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return tie_score;
      3:       return reg_thr;
      4:       return reg_thr + 1'b1;
      default: return ScoreW'($urandom);
    endcase
  endfunction

  function automatic void add_row(logic op, logic [ScoreW-1:0] score, logic first,
                                  bit typed = 1'b0, out_item_t peak = NOT_FOUND);
    dir_row_t row;
    row.item.op            = op;
    row.item.score         = score;
    row.item.first_element = first;
    row.typed              = typed;
    row.peak               = peak;
    dir_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------
  // Idle for a random gap, present the item, hold it until the transfer, then
  // update the shadow state and queue any report. Valid stays high when the
  // next item follows without a gap.
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t typed_res = NOT_FOUND);
    out_item_t   res;
    int unsigned gap;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sent++;
    if (take_item(it, res)) peaks_due.push_back(typed ? typed_res : res);
  endtask

  task automatic load_score(logic [ScoreW-1:0] score, logic first);
    in_item_t it;
    it.op            = OP_LOAD;
    it.score         = score;
    it.first_element = first;
    send_item(it);
  endtask

  // The score and first_element bits carry noise on a find.
  task automatic find_peak();
    in_item_t it;
    it.op            = OP_FIND;
    it.score         = ScoreW'($urandom);
    it.first_element = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MAP_WIDTH:   reg_width  = val[CfgDimW-1:0];
      REG_MAP_HEIGHT:  reg_height = val[CfgDimW-1:0];
      REG_THRESHOLD:   reg_thr    = val[ScoreW-1:0];
      REG_BLOT_RADIUS: reg_radius = val[RadiusW-1:0];
      REG_HIT_LIMIT:   reg_limit  = val[HitW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h,
                              logic [CfgDataW-1:0] thr, logic [CfgDataW-1:0] rad,
                              logic [CfgDataW-1:0] lim);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_BLOT_RADIUS, rad);
    write_reg(REG_HIT_LIMIT, lim);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every report and let a trailing load pass, so that
  // registers change only while the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (peaks_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random settings, small maps mostly. The first phases force the extremes.
  task automatic random_regs(int unsigned phase);
    logic [CfgDataW-1:0] w, h, thr, rad, lim;
    w   = CfgDataW'($urandom_range(1, 8));
    h   = CfgDataW'($urandom_range(1, 8));
    thr = CfgDataW'($urandom);
    rad = CfgDataW'($urandom_range(0, 3));
    lim = CfgDataW'($urandom_range(1, 8));
    // Long thin maps reach the size limits without slow full-map scans.
    case ($urandom_range(0, 9))
      0:       begin w = 16'd64; h = CfgDataW'($urandom_range(0, 2)); end
      1:       begin w = CfgDataW'($urandom_range(0, 2)); h = 16'd64; end
      2:       begin w = CfgDataW'($urandom_range(65, 127)); h = CfgDataW'($urandom_range(0, 1)); end
      3:       begin w = CfgDataW'($urandom_range(0, 1)); h = CfgDataW'($urandom_range(65, 127)); end
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = CfgDataW'($urandom_range(0, 255));
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       rad = 16'd0;
      1:       rad = 16'd16;
      2:       rad = 16'd31;
      3:       rad = CfgDataW'($urandom_range(4, 15));
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       lim = 16'd0;
      1:       lim = 16'd1023;
      2:       lim = CfgDataW'($urandom_range(9, 1022));
      default: ;
    endcase
    case (phase)
      0:       begin rad = 16'd0; lim = 16'd0; end
      1:       begin w = 16'd0; h = 16'd127; thr = '0; end
      2:       begin w = 16'd64; h = 16'd1; thr = '1; rad = 16'd16; lim = 16'd1023; end
      3:       begin w = 16'd127; h = 16'd0; rad = 16'd31; lim = 16'd1; end
      default: ;
    endcase
    // Set junk in the data bits above each register now and then.
    if ($urandom_range(0, 1)) w[CfgDataW-1:CfgDimW] = (CfgDataW-CfgDimW)'($urandom);
    if ($urandom_range(0, 1)) h[CfgDataW-1:CfgDimW] = (CfgDataW-CfgDimW)'($urandom);
    if ($urandom_range(0, 1)) rad[CfgDataW-1:RadiusW] = (CfgDataW-RadiusW)'($urandom);
    if ($urandom_range(0, 1)) lim[CfgDataW-1:HitW] = (CfgDataW-HitW)'($urandom);
    program_regs(w, h, thr, rad, lim);
  endtask

  // One phase: new settings, then mostly a complete map followed by finds,
  // sometimes a partial reload, a load run without a new-map flag, or no
  // loads at all. Loads slipped between finds change the map mid-search.
  task automatic run_phase(int unsigned phase);
    int unsigned cells, count, finds, style;
    settle();
    random_regs(phase);
    in_calm   = ($urandom_range(0, 4) == 0);
    out_calm  = ($urandom_range(0, 4) == 0);
    tie_score = ScoreW'($urandom);
    cells     = used_dim(reg_width, MapW) * used_dim(reg_height, MapH);
    style     = $urandom_range(0, 9);
    count     = (style < 7) ? cells : $urandom_range(1, cells);
    if (style < 9) begin
      for (int unsigned i = 0; i < count; i++)
        load_score(pick_score(), (style != 8) && (i == 0));
    end
    finds = $urandom_range(1, 16);
    for (int unsigned i = 0; i < finds; i++) begin
      if ($urandom_range(0, 9) == 0) load_score(pick_score(), $urandom_range(0, 3) == 0);
      // Never let a live search scan entries that were never written.
      if (!search_done && cells > high_water) break;
      find_peak();
      if (search_done && $urandom_range(0, 1)) break;
    end
  endtask

  // --------------------------------------------------------------------------
  // Output channel
  // --------------------------------------------------------------------------
  // Stall for a random count of cycles, then release and wait for the next
  // transfer.
  initial begin : result_stall
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = draw_wait(out_calm);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while (!out_valid_o);
    end
  end

  task automatic cmp_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Compare each report transfer with the oldest one due.
  always @(posedge clk_i) begin : check_reports
    out_item_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (peaks_due.size() == 0) begin
        $display("%0t: unexpected report: expected none, got %p", $time, out_data_o);
        mismatches++;
      end else begin
        due = peaks_due.pop_front();
        cmp_field("found", 32'(due.found), 32'(out_data_o.found));
        cmp_field("peak_x", 32'(due.peak_x), 32'(out_data_o.peak_x));
        cmp_field("peak_y", 32'(due.peak_y), 32'(out_data_o.peak_y));
        cmp_field("peak_score", 32'(due.peak_score), 32'(out_data_o.peak_score));
        cmp_field("last", 32'(due.last), 32'(out_data_o.last));
      end
    end
  end

  // Hang detection: count cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase, mark;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on a 4x2 map, radius 1, threshold 100, at most 3 hits.
    program_regs(16'd4, 16'd2, 16'd100, 16'd1, 16'd3);
    // Nothing loaded yet: the search counts as ended, first_element is ignored.
    add_row(OP_FIND, 16'h0000, 1'b0, 1'b1, NOT_FOUND);
    add_row(OP_FIND, 16'hFFFF, 1'b1, 1'b1, NOT_FOUND);
    // Row 0: FFFF 0000 0007 FFFF, row 1: 00C8 8000 0001 0000.
    add_row(OP_LOAD, 16'hFFFF, 1'b1);
    add_row(OP_LOAD, 16'h0000, 1'b0);
    add_row(OP_LOAD, 16'h0007, 1'b0);
    add_row(OP_LOAD, 16'hFFFF, 1'b0);
    add_row(OP_LOAD, 16'h00C8, 1'b0);
    add_row(OP_LOAD, 16'h8000, 1'b0);
    add_row(OP_LOAD, 16'h0001, 1'b0);
    add_row(OP_LOAD, 16'h0000, 1'b0);
    // Tie on the top score: the first in scan order wins.
    add_row(OP_FIND, 16'h0000, 1'b0, 1'b1,
            '{found: 1'b1, peak_x: '0, peak_y: '0, peak_score: 16'hFFFF, last: 1'b0});
    add_row(OP_FIND, 16'h0000, 1'b0);
    // Third hit reaches the limit and the remainder falls under the threshold.
    add_row(OP_FIND, 16'h0000, 1'b0);
    add_row(OP_FIND, 16'h0000, 1'b0, 1'b1, NOT_FOUND);
    // A load without a new-map flag leaves the ended search alone.
    add_row(OP_LOAD, 16'h1234, 1'b0);
    add_row(OP_FIND, 16'h0000, 1'b0, 1'b1, NOT_FOUND);
    // New map: the first hit is reported even below the threshold.
    add_row(OP_LOAD, 16'h0032, 1'b1);
    add_row(OP_FIND, 16'h0000, 1'b0);
    add_row(OP_FIND, 16'h0000, 1'b0, 1'b1, NOT_FOUND);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].peak);

    // Random part.
    phase = 0;
    mark  = sent;
    while (sent < mark + RandomItems) begin
      run_phase(phase);
      phase++;
    end

    // Drain: wait for the last reports, then watch for strays.
    in_valid_i <= 1'b0;
    while (peaks_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gps_pkg.sv
hw/rtl/gps_ram.sv
hw/rtl/gps_max_unit.sv
hw/rtl/greedy_peak_suppression.sv
hw/rtl/gps_checker.sv
tb/tb_greedy_peak_suppression.sv
